// ===== hw/rtl/sprite_frame_animator_defines.svh =====
// assertion macros used by the sprite frame animator controller
`ifndef SPRITE_FRAME_ANIMATOR_DEFINES_SVH
`define SPRITE_FRAME_ANIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define SFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite frame animator check failed");
// next-cycle implication, disabled while in reset
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite frame animator check failed");
`else
`define SFA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/sfa_pkg.sv =====
// types and constants of the sprite frame animator
package sfa_pkg;

    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_PLAY        = 3'd1;
    localparam logic [2:0] CMD_PAUSE       = 3'd2;
    localparam logic [2:0] CMD_RESUME      = 3'd3;
    localparam logic [2:0] CMD_STOP        = 3'd4;
    localparam logic [2:0] CMD_WRITE_FRAME = 3'd5;
    localparam logic [2:0] CMD_WRITE_ANIM  = 3'd6;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_PLAYING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_H       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_V       = 2'd2;

    localparam logic [15:0] SPEED_ONE = 16'd256;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  anim_id;
        logic [3:0]  frame_index;
        logic [15:0] time_value;
        logic [15:0] entry_left_u;
        logic [15:0] entry_top_v;
        logic [15:0] entry_right_u;
        logic [15:0] entry_bottom_v;
        logic [4:0]  frame_total;
        logic        loop_flag;
        logic [15:0] anim_speed;
        logic        restart;
    } item_t;

    typedef struct packed {
        logic [15:0] left_u;
        logic [15:0] top_v;
        logic [15:0] right_u;
        logic [15:0] bottom_v;
        logic [3:0]  current_frame;
        logic [1:0]  play_state;
        logic        frame_advanced;
    } result_t;

    typedef struct packed {
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] r;
        logic [15:0] b;
    } rect_t;

    typedef struct packed {
        logic [15:0] dur;
        rect_t       rect;
    } frame_entry_t;

    typedef struct packed {
        logic [4:0]  count;
        logic        loop;
        logic [15:0] speed;
    } desc_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic fetch;
        logic add;
        logic step;
        logic load_rect;
        logic out_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic live_tick;
        logic step_hit;
    } status_t;

endpackage

// ===== hw/rtl/sfa_if.sv =====
// valid/ready channel interfaces for items, results and register writes
interface sfa_item_if;
    import sfa_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfa_result_if;
    import sfa_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfa_cfg_if;
    import sfa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sfa_ram.sv =====
// generic simple dual-port ram with registered read
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sfa_ctrl.sv =====
// sequencing state machine of the sprite frame animator
`include "sprite_frame_animator_defines.svh"

module sfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sfa_pkg::status_t  status,
    output sfa_pkg::ctrl_t    ctrl
);
    import sfa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ctrl.fetch = 1'b1;
                state_next = status.live_tick ? S_ADD : S_OUT;
            end
            S_ADD:
            begin
                ctrl.add   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                ctrl.step  = 1'b1;
                state_next = status.step_hit ? S_LOAD : S_OUT;
            end
            S_LOAD:
            begin
                ctrl.load_rect = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted item always starts with the table fetch
    `SFA_ASSERT_NEXT(a_accept_fetch, clk, rst_n, accept, state_reg == S_FETCH)
    // a pending result is never overwritten
    `SFA_ASSERT_NOW(a_no_overwrite, clk, rst_n, ctrl.out_load, !out_valid_reg || out_ready)
    // a rectangle reload only follows a frame step
    `SFA_ASSERT_NOW(a_load_after_cmp, clk, rst_n, state_reg == S_LOAD, $past(state_reg) == S_CMP)

endmodule

// ===== hw/rtl/sfa_datapath.sv =====
// registers, tables and arithmetic of the sprite frame animator
module sfa_datapath #(
    parameter int NUM_ANIMS  = 8,
    parameter int MAX_FRAMES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sfa_pkg::ctrl_t                  ctrl,
    output sfa_pkg::status_t                status,
    input  sfa_pkg::item_t                  item_data,
    input  logic                            cfg_write,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfa_pkg::result_t                result_data
);
    import sfa_pkg::*;

    localparam int AW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int DEPTH = NUM_ANIMS * MAX_FRAMES;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDW   = (AW > 3) ? AW : 3;
    localparam int FIW   = (FW > 4) ? FW : 4;
    localparam int NW    = (FW + 1 > 5) ? FW + 1 : 5;

    function automatic logic [SW-1:0] slot_of(input logic [AW-1:0] anim,
                                              input logic [FW-1:0] frame);
        return SW'(anim) * SW'(MAX_FRAMES) + SW'(frame);
    endfunction

    // configuration
    logic [15:0] sprite_speed_reg;
    logic        flip_h_reg;
    logic        flip_v_reg;

    // animation state
    logic [1:0]          run_state_reg;
    logic [AW-1:0]       active_reg;
    logic [FW-1:0]       frame_reg;
    logic [31:0]         timer_reg;
    rect_t               shown_reg;
    logic [NUM_ANIMS-1:0] desc_vld_reg;
    logic                advanced_reg;
    logic                dvld_q_reg;

    // item payload and products
    item_t       item_reg;
    logic [31:0] pm_reg;
    logic [31:0] inc_reg;
    result_t     result_reg;

    // ram ports
    logic         frame_wr_en;
    logic [SW-1:0] frame_wr_addr;
    frame_entry_t frame_wr_data;
    logic         frame_rd_en;
    logic [SW-1:0] frame_rd_addr;
    frame_entry_t frame_rd_data;
    logic          desc_wr_en;
    logic [AW-1:0] desc_wr_addr;
    desc_t         desc_wr_data;
    logic [AW-1:0] desc_rd_addr;
    desc_t         desc_rd_data;

    logic [IDW-1:0] in_id_w;
    logic [AW-1:0]  in_id_addr;
    logic [IDW-1:0] it_id_w;
    logic [AW-1:0]  it_id_addr;
    logic [FIW-1:0] it_fi_w;
    logic [FW-1:0]  it_fi_addr;
    logic           in_is_tick;
    logic           id_ok;
    logic           fidx_ok;
    logic [4:0]     count_f;
    logic [4:0]     count_sat;
    logic           same_playing;
    logic [47:0]    inc_full;
    logic [32:0]    sum;
    logic           hit;
    logic [NW-1:0]  next_num;
    logic [NW-1:0]  count_w;
    logic [NW-1:0]  last_num;
    logic [FW-1:0]  step_frame;
    logic           step_stop;
    logic [FIW-1:0] frame_w;

    assign in_id_w    = IDW'(item_data.anim_id);
    assign in_id_addr = in_id_w[AW-1:0];
    assign it_id_w    = IDW'(item_reg.anim_id);
    assign it_id_addr = it_id_w[AW-1:0];
    assign it_fi_w    = FIW'(item_reg.frame_index);
    assign it_fi_addr = it_fi_w[FW-1:0];
    assign in_is_tick = (item_data.command == CMD_TICK);
    assign id_ok      = int'(item_reg.anim_id) < NUM_ANIMS;
    assign fidx_ok    = int'(item_reg.frame_index) < MAX_FRAMES;

    // descriptor as read at accept, absent when never written
    assign count_f      = dvld_q_reg ? desc_rd_data.count : 5'd0;
    assign count_sat    = (int'(item_reg.frame_total) > MAX_FRAMES) ? 5'(MAX_FRAMES)
                                                                    : item_reg.frame_total;
    assign same_playing = (IDW'(active_reg) == it_id_w) && !item_reg.restart
                          && (run_state_reg == ST_PLAYING);

    assign status.live_tick = (item_reg.command == CMD_TICK)
                              && (run_state_reg == ST_PLAYING) && (count_f != 5'd0);

    assign inc_full = 48'(pm_reg) * 48'(desc_rd_data.speed);
    assign sum      = {1'b0, timer_reg} + {1'b0, inc_reg};

    // frame step: wrap or one-shot hold on the last frame
    assign hit             = timer_reg >= {16'd0, frame_rd_data.dur};
    assign status.step_hit = hit;
    assign next_num        = NW'(frame_reg) + NW'(1);
    assign count_w         = NW'(count_f);
    assign last_num        = count_w - NW'(1);
    always_comb
    begin
        step_frame = FW'(next_num);
        step_stop  = 1'b0;
        if (next_num >= count_w)
        begin
            if (desc_rd_data.loop)
            begin
                step_frame = '0;
            end
            else
            begin
                step_frame = FW'(last_num);
                step_stop  = 1'b1;
            end
        end
    end

    // ram control
    assign desc_rd_addr  = in_is_tick ? active_reg : in_id_addr;
    assign frame_rd_en   = ctrl.capture || ctrl.step;
    assign frame_rd_addr = ctrl.capture ? (in_is_tick ? slot_of(active_reg, frame_reg)
                                                      : slot_of(in_id_addr, '0))
                                        : slot_of(active_reg, step_frame);

    assign frame_wr_en   = ctrl.fetch && (item_reg.command == CMD_WRITE_FRAME)
                           && id_ok && fidx_ok;
    assign frame_wr_addr = slot_of(it_id_addr, it_fi_addr);
    assign frame_wr_data = '{dur: item_reg.time_value,
                             rect: '{l: item_reg.entry_left_u, t: item_reg.entry_top_v,
                                     r: item_reg.entry_right_u, b: item_reg.entry_bottom_v}};

    assign desc_wr_en   = ctrl.fetch && (item_reg.command == CMD_WRITE_ANIM) && id_ok;
    assign desc_wr_addr = it_id_addr;
    assign desc_wr_data = '{count: count_sat, loop: item_reg.loop_flag,
                            speed: item_reg.anim_speed};

    sfa_ram #(
        .WIDTH ($bits(frame_entry_t)),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr (frame_wr_addr),
        .wr_data (frame_wr_data),
        .rd_en   (frame_rd_en),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_data)
    );

    sfa_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (NUM_ANIMS)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_wr_en),
        .wr_addr (desc_wr_addr),
        .wr_data (desc_wr_data),
        .rd_en   (ctrl.capture),
        .rd_addr (desc_rd_addr),
        .rd_data (desc_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_speed_reg <= SPEED_ONE;
            flip_h_reg       <= 1'b0;
            flip_v_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPRITE_SPEED: sprite_speed_reg <= cfg_data;
                CFG_FLIP_H:       flip_h_reg       <= cfg_data[0];
                CFG_FLIP_V:       flip_v_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= item_data;
            pm_reg   <= 32'(item_data.time_value) * 32'(sprite_speed_reg);
        end
        if (ctrl.fetch)
        begin
            inc_reg <= inc_full[47:16];
        end
        if (ctrl.out_load)
        begin
            result_reg.left_u         <= flip_h_reg ? shown_reg.r : shown_reg.l;
            result_reg.top_v          <= flip_v_reg ? shown_reg.b : shown_reg.t;
            result_reg.right_u        <= flip_h_reg ? shown_reg.l : shown_reg.r;
            result_reg.bottom_v       <= flip_v_reg ? shown_reg.t : shown_reg.b;
            result_reg.current_frame  <= frame_w[3:0];
            result_reg.play_state     <= run_state_reg;
            result_reg.frame_advanced <= advanced_reg;
        end
    end

    assign frame_w     = FIW'(frame_reg);
    assign result_data = result_reg;

    // animation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_state_reg <= ST_STOPPED;
            active_reg    <= '0;
            frame_reg     <= '0;
            timer_reg     <= '0;
            shown_reg     <= '{l: 16'h0000, t: 16'h0000, r: 16'hFFFF, b: 16'hFFFF};
            desc_vld_reg  <= '0;
            advanced_reg  <= 1'b0;
            dvld_q_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                advanced_reg <= 1'b0;
                dvld_q_reg   <= desc_vld_reg[desc_rd_addr];
            end
            if (ctrl.fetch)
            begin
                case (item_reg.command)
                    CMD_PLAY:
                    begin
                        if (!same_playing && id_ok && (count_f != 5'd0))
                        begin
                            active_reg    <= it_id_addr;
                            frame_reg     <= '0;
                            timer_reg     <= '0;
                            run_state_reg <= ST_PLAYING;
                            shown_reg     <= frame_rd_data.rect;
                        end
                    end
                    CMD_PAUSE:
                    begin
                        if (run_state_reg == ST_PLAYING)
                        begin
                            run_state_reg <= ST_PAUSED;
                        end
                    end
                    CMD_RESUME:
                    begin
                        if (run_state_reg == ST_PAUSED)
                        begin
                            run_state_reg <= ST_PLAYING;
                        end
                    end
                    CMD_STOP:
                    begin
                        run_state_reg <= ST_STOPPED;
                        frame_reg     <= '0;
                        timer_reg     <= '0;
                    end
                    CMD_WRITE_ANIM:
                    begin
                        if (id_ok)
                        begin
                            desc_vld_reg[it_id_addr] <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctrl.add)
            begin
                // saturating accumulate
                timer_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            if (ctrl.step && hit)
            begin
                timer_reg <= timer_reg - {16'd0, frame_rd_data.dur};
                frame_reg <= step_frame;
                if (step_stop)
                begin
                    run_state_reg <= ST_STOPPED;
                end
            end
            if (ctrl.load_rect)
            begin
                shown_reg    <= frame_rd_data.rect;
                advanced_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/sprite_frame_animator.sv =====
// top level of the sprite frame animator
// sequence: table fetch, then for a live tick timer add and frame compare, a rectangle
// load when it steps, and the result register load; one item at a time, since the
// controller walks the frame table's one read port (duration, then next rectangle);
// a result still waiting for its transfer holds the next one back in the output state
// reset: stopped on frame 0, timer 0, full-texture rectangle, no animations, speed 1.0
module sprite_frame_animator #(
    parameter int NUM_ANIMS  = 8,
    parameter int MAX_FRAMES = 16
) (
    input logic          clk,
    input logic          rst_n,
    sfa_item_if.sink     items,
    sfa_result_if.source results,
    sfa_cfg_if.sink      cfg
);
    import sfa_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    cfg_write;

    // register writes are always taken; the user only writes while idle
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // controller: one item at a time, result held in its own register so the
    // next item transfer can start while the previous result waits
    sfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // datapath: frame and descriptor tables, timer arithmetic, shown rectangle
    // frame table contents are undefined until written; no clearing pass
    sfa_datapath #(
        .NUM_ANIMS  (NUM_ANIMS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .item_data   (items.data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result_data (results.data)
    );

endmodule
